FILE: hdl/sha256_stream_hash_defines.svh
// Assertion macros for the streaming SHA-256 block.
`ifndef SHA256_STREAM_HASH_DEFINES_SVH
`define SHA256_STREAM_HASH_DEFINES_SVH
`ifndef ASSERT_OFF
`define SHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/sha_pkg.sv
// Shared types, constants and functions of the streaming SHA-256 block.
`default_nettype none
package sha_pkg;
	localparam int unsigned BlockBytes = 64;
	localparam int unsigned Rounds = 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic        buf_write;
		logic [1:0]  pad_sel;
		logic        init_work;
		logic        round_en;
		logic        fold;
		logic        reset_chain;
		logic        count_byte;
		logic [5:0]  round_idx;
		logic [5:0]  byte_idx;
	} cmd_t;

	localparam logic [1:0] PAD_DATA = 2'd0;
	localparam logic [1:0] PAD_MARK = 2'd1;
	localparam logic [1:0] PAD_ZERO = 2'd2;
	localparam logic [1:0] PAD_LEN  = 2'd3;

	localparam logic [7:0] PadMarker = 8'h80;
	localparam logic [5:0] LenStart = 6'd56;

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage
`default_nettype wire

FILE: hdl/sha256_stream_hash.sv
// Streaming SHA-256: top level joining controller and datapath.
// Each byte is taken in the idle state; a full block then passes through load, 64 rounds and fold.
// An end item pads byte by byte, compresses one or two blocks, then offers eight words.
// New bytes are stalled while a block is compressed by the single round unit.
// Reset arst_n is asynchronous, active low; the chain returns to the initial hash values.
// The block buffer is written before it is read and needs no clearing pass.
`default_nettype none
module sha256_stream_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_present,
	input  wire logic        end_of_message,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	sha_pkg::cmd_t cmd;

	sha_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.word_index     (word_index),
		.last_word      (last_word),
		.cmd            (cmd)
	);

	sha_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.out_sel     (word_index),
		.digest_word (digest_word)
	);
endmodule
`default_nettype wire

FILE: hdl/sha_datapath.sv
// Datapath: block buffer, schedule, round logic, chaining words and byte count.
`default_nettype none
module sha_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sha_pkg::cmd_t cmd,
	input  wire logic [7:0]    data_byte,
	input  wire logic [2:0]    out_sel,
	output logic [31:0]        digest_word
);
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [63:0] total_q;
	logic [63:0] bits;
	logic [7:0]  wr_byte;
	logic [31:0] w15, w2, s0, s1, w_new, w_cur, t1, t2;
	logic [3:0]  ri;

	assign bits = {total_q[60:0], 3'b000};

	// Select the byte stored into the buffer
	always_comb begin
		case (cmd.pad_sel)
			sha_pkg::PAD_DATA: wr_byte = data_byte;
			sha_pkg::PAD_MARK: wr_byte = sha_pkg::PadMarker;
			sha_pkg::PAD_LEN:  wr_byte = bits[{~cmd.byte_idx[2:0], 3'b000} +: 8];
			default:           wr_byte = 8'h00;
		endcase
	end

	// Round arithmetic
	always_comb begin
		ri = cmd.round_idx[3:0];
		w15 = w_q[ri + 4'd1];
		w2 = w_q[ri + 4'd14];
		s0 = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
		s1 = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
		w_new = w_q[ri] + s0 + w_q[ri + 4'd9] + s1;
		w_cur = (cmd.round_idx < 6'd16) ? w_q[ri] : w_new;
		t1 = v_q[7] + (sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11)
			^ sha_pkg::rotr(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha_pkg::RoundK[cmd.round_idx] + w_cur;
		t2 = (sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13)
			^ sha_pkg::rotr(v_q[0], 22)) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2])
			^ (v_q[1] & v_q[2]));
	end

	// Schedule words hold the block buffer: pack each byte big-endian into its word
	always_ff @(posedge clk) begin
		if (cmd.round_en) begin
			w_q[ri] <= w_cur;
		end else if (cmd.buf_write) begin
			w_q[cmd.byte_idx[5:2]][{~cmd.byte_idx[1:0], 3'b000} +: 8] <= wr_byte;
		end
	end

	// Working variables
	always_ff @(posedge clk) begin
		if (cmd.init_work) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (cmd.round_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// Chaining words and byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha_pkg::InitHash[i];
			end
			total_q <= '0;
		end else begin
			if (cmd.reset_chain) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= sha_pkg::InitHash[i];
				end
			end else if (cmd.fold) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
			end
			if (cmd.reset_chain) begin
				total_q <= '0;
			end else if (cmd.count_byte) begin
				total_q <= total_q + 64'd1;
			end
		end
	end

	assign digest_word = h_q[out_sel];
endmodule
`default_nettype wire

FILE: hdl/sha_ctrl.sv
// Controller: sequences byte intake, compression rounds, padding and digest output.
`default_nettype none
`include "sha256_stream_hash_defines.svh"
module sha_ctrl (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       byte_present,
	input  wire logic       end_of_message,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      word_index,
	output logic            last_word,
	output sha_pkg::cmd_t   cmd
);
	sha_pkg::state_t state_q, state_d;
	logic [5:0] fill_q, fill_d;
	logic [5:0] round_q, round_d;
	logic [2:0] word_q, word_d;
	logic       pend_end_q, pend_end_d;
	logic       final_q, final_d;
	logic       extra_q, extra_d;
	logic       accept;

	assign accept = in_valid && !in_stall;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::ST_IDLE;
			fill_q <= '0;
			round_q <= '0;
			word_q <= '0;
			pend_end_q <= 1'b0;
			final_q <= 1'b0;
			extra_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q <= fill_d;
			round_q <= round_d;
			word_q <= word_d;
			pend_end_q <= pend_end_d;
			final_q <= final_d;
			extra_q <= extra_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		fill_d = fill_q;
		round_d = round_q;
		word_d = word_q;
		pend_end_d = pend_end_q;
		final_d = final_q;
		extra_d = extra_q;
		cmd = '0;
		cmd.round_idx = round_q;
		cmd.byte_idx = fill_q;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			sha_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (byte_present) begin
						cmd.buf_write = 1'b1;
						cmd.pad_sel = sha_pkg::PAD_DATA;
						cmd.count_byte = 1'b1;
						fill_d = fill_q + 6'd1;
					end
					pend_end_d = end_of_message;
					final_d = 1'b0;
					if (byte_present && fill_q == 6'd63) begin
						state_d = sha_pkg::ST_LOAD;
					end else if (end_of_message) begin
						state_d = sha_pkg::ST_PAD;
						final_d = 1'b0;
						// mark written next cycle at fill position
						pend_end_d = 1'b1;
					end
				end
			end
			sha_pkg::ST_LOAD: begin
				cmd.init_work = 1'b1;
				round_d = '0;
				state_d = sha_pkg::ST_ROUND;
			end
			sha_pkg::ST_ROUND: begin
				cmd.round_en = 1'b1;
				round_d = round_q + 6'd1;
				if (round_q == 6'd63) begin
					state_d = sha_pkg::ST_FOLD;
				end
			end
			sha_pkg::ST_FOLD: begin
				cmd.fold = 1'b1;
				if (final_q) begin
					word_d = '0;
					state_d = sha_pkg::ST_EMIT;
				end else if (pend_end_q || extra_q) begin
					// Padding goes on in the next block
					extra_d = 1'b0;
					state_d = sha_pkg::ST_PAD;
				end else begin
					state_d = sha_pkg::ST_IDLE;
				end
			end
			sha_pkg::ST_PAD: begin
				// First pad cycle after an end writes the marker
				cmd.buf_write = 1'b1;
				fill_d = fill_q + 6'd1;
				if (pend_end_q) begin
					cmd.pad_sel = sha_pkg::PAD_MARK;
					pend_end_d = 1'b0;
				end else if (final_q && fill_q >= sha_pkg::LenStart) begin
					cmd.pad_sel = sha_pkg::PAD_LEN;
				end else begin
					cmd.pad_sel = sha_pkg::PAD_ZERO;
				end
				if (pend_end_q && fill_q <= 6'd55) begin
					final_d = 1'b1;
				end
				if (fill_q == 6'd63) begin
					state_d = sha_pkg::ST_LOAD;
					// No room for the length: it follows in an extra block
					if (!final_q) begin
						extra_d = 1'b1;
					end
				end else if (fill_q == 6'd55 && !pend_end_q && !final_q) begin
					// Zeros reached the length field: switch to the final block
					final_d = 1'b1;
				end
				if (pend_end_q && fill_q == 6'd63) begin
					final_d = 1'b0;
				end
			end
			sha_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					word_d = word_q + 3'd1;
					if (word_q == 3'd7) begin
						cmd.reset_chain = 1'b1;
						fill_d = '0;
						final_d = 1'b0;
						state_d = sha_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = sha_pkg::ST_IDLE;
			end
		endcase
	end

	assign word_index = word_q;
	assign last_word = (word_q == 3'd7);

	`SHA_ASSERT_IMP(a_out_only_emit, clk, arst_n, out_valid, state_q == sha_pkg::ST_EMIT)
	`SHA_ASSERT_IMP(a_take_only_idle, clk, arst_n, accept, state_q == sha_pkg::ST_IDLE)
	`SHA_ASSERT_NXT(a_round_to_fold, clk, arst_n,
		state_q == sha_pkg::ST_ROUND && round_q == 6'd63, state_q == sha_pkg::ST_FOLD)
	`SHA_ASSERT_NXT(a_chain_reset, clk, arst_n,
		out_valid && !out_stall && last_word, state_q == sha_pkg::ST_IDLE && fill_q == 6'd0)
endmodule
`default_nettype wire
